// File: hw/rtl/rfp_pkg.sv
// ----------------------------------------------------------------------------
// Relocation fixup patcher package
// Shared widths, codes, masks and pipeline word types.
// ----------------------------------------------------------------------------
package rfp_pkg;

  localparam int ADDR_W   = 64;
  localparam int WORD_W   = 32;
  localparam int OP_W     = 4;
  localparam int PLAN_W   = 3;
  localparam int SLOT_W   = 12;
  localparam int STATUS_W = 3;
  localparam int SIZE_W   = 2;
  localparam int DKIND_W  = 2;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 64;

  localparam logic [OP_W-1:0] OP_NONE         = 4'd0;
  localparam logic [OP_W-1:0] OP_X86_ABS64    = 4'd1;
  localparam logic [OP_W-1:0] OP_X86_PC32     = 4'd2;
  localparam logic [OP_W-1:0] OP_X86_GOTPCREL = 4'd3;
  localparam logic [OP_W-1:0] OP_A64_ABS64    = 4'd4;
  localparam logic [OP_W-1:0] OP_A64_CALL26   = 4'd5;
  localparam logic [OP_W-1:0] OP_A64_ADRP     = 4'd6;
  localparam logic [OP_W-1:0] OP_A64_ADD_LO12 = 4'd7;
  localparam logic [OP_W-1:0] OP_A64_LD64_LO12 = 4'd8;
  localparam logic [OP_W-1:0] OP_A64_LD32_LO12 = 4'd9;

  localparam logic [PLAN_W-1:0] PLAN_STATIC   = 3'd0;
  localparam logic [PLAN_W-1:0] PLAN_RELATIVE = 3'd1;
  localparam logic [PLAN_W-1:0] PLAN_DYN_ABS  = 3'd2;
  localparam logic [PLAN_W-1:0] PLAN_PLT      = 3'd3;
  localparam logic [PLAN_W-1:0] PLAN_GOT      = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNRESOLVED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PLAN       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_KIND       = 3'd4;

  localparam logic [SIZE_W-1:0] WS_NONE  = 2'd0;
  localparam logic [SIZE_W-1:0] WS_FOUR  = 2'd1;
  localparam logic [SIZE_W-1:0] WS_EIGHT = 2'd2;

  localparam logic [DKIND_W-1:0] DK_NONE     = 2'd0;
  localparam logic [DKIND_W-1:0] DK_RELATIVE = 2'd1;
  localparam logic [DKIND_W-1:0] DK_SYMBOLIC = 2'd2;

  localparam logic [WORD_W-1:0] RT_X86_ABS64    = 32'd1;
  localparam logic [WORD_W-1:0] RT_X86_RELATIVE = 32'd8;
  localparam logic [WORD_W-1:0] RT_A64_ABS64    = 32'd257;
  localparam logic [WORD_W-1:0] RT_A64_RELATIVE = 32'd1027;

  localparam logic [WORD_W-1:0] MASK_B26  = 32'h03FF_FFFF;
  localparam logic [WORD_W-1:0] MASK_LO12 = 32'h003F_FC00;
  localparam logic [WORD_W-1:0] MASK_ADRP = 32'h60FF_FFE0;

  localparam logic [ADDR_W-1:0] PLT_HDR_X86 = 64'd16;
  localparam logic [ADDR_W-1:0] PLT_HDR_A64 = 64'd32;

  localparam logic [CFG_AW-1:0] CFG_GOT_ADDR = 4'h0;
  localparam logic [CFG_AW-1:0] CFG_PLT_ADDR = 4'h8;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [PLAN_W-1:0] plan;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] sym_address;
    logic              sym_defined;
    logic              sym_dynamic;
    logic              sym_weak;
    logic              sym_redirected;
    logic [ADDR_W-1:0] addend;
    logic [ADDR_W-1:0] place_address;
    logic [WORD_W-1:0] old_word;
    logic [WORD_W-1:0] dyn_sym_index;
  } rfp_rec_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [PLAN_W-1:0]   plan;
    logic [ADDR_W-1:0]   target;
    logic [ADDR_W-1:0]   addend;
    logic [ADDR_W-1:0]   place;
    logic [WORD_W-1:0]   word;
    logic [WORD_W-1:0]   dsym;
    logic [STATUS_W-1:0] status;
  } rfp_tgt_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [PLAN_W-1:0]   plan;
    logic [ADDR_W-1:0]   sa;
    logic [ADDR_W-1:0]   addend;
    logic [ADDR_W-1:0]   place;
    logic [WORD_W-1:0]   word;
    logic [WORD_W-1:0]   dsym;
    logic [STATUS_W-1:0] status;
  } rfp_sum_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [PLAN_W-1:0]   plan;
    logic [ADDR_W-1:0]   sa;
    logic [ADDR_W-1:0]   diff;
    logic [ADDR_W-1:0]   addend;
    logic [WORD_W-1:0]   word;
    logic [WORD_W-1:0]   dsym;
    logic [STATUS_W-1:0] status;
  } rfp_diff_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   new_value;
    logic [SIZE_W-1:0]   write_size;
    logic [STATUS_W-1:0] status;
    logic [DKIND_W-1:0]  dyn_kind;
    logic [ADDR_W-1:0]   dyn_info;
    logic [ADDR_W-1:0]   dyn_addend;
  } rfp_res_t;

endpackage

// File: hw/rtl/rfp_if.sv
// ----------------------------------------------------------------------------
// Relocation fixup patcher channels
// Valid/ready interfaces for the relocation record and patch result words.
// ----------------------------------------------------------------------------
interface rfp_in_if
  import rfp_pkg::*;
  ;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [PLAN_W-1:0]        plan;
  logic [SLOT_W-1:0]        slot;
  logic [ADDR_W-1:0]        sym_address;
  logic                     sym_defined;
  logic                     sym_dynamic;
  logic                     sym_weak;
  logic                     sym_redirected;
  logic signed [ADDR_W-1:0] addend;
  logic [ADDR_W-1:0]        place_address;
  logic [WORD_W-1:0]        old_word;
  logic [WORD_W-1:0]        dyn_sym_index;

  modport source (
    output valid, op, plan, slot, sym_address, sym_defined, sym_dynamic, sym_weak,
           sym_redirected, addend, place_address, old_word, dyn_sym_index,
    input  ready
  );
  modport sink (
    input  valid, op, plan, slot, sym_address, sym_defined, sym_dynamic, sym_weak,
           sym_redirected, addend, place_address, old_word, dyn_sym_index,
    output ready
  );
endinterface

interface rfp_out_if
  import rfp_pkg::*;
  ;
  logic                     valid;
  logic                     ready;
  logic [ADDR_W-1:0]        new_value;
  logic [SIZE_W-1:0]        write_size;
  logic [STATUS_W-1:0]      status;
  logic [DKIND_W-1:0]       dyn_kind;
  logic [ADDR_W-1:0]        dyn_info;
  logic signed [ADDR_W-1:0] dyn_addend;

  modport source (
    output valid, new_value, write_size, status, dyn_kind, dyn_info, dyn_addend,
    input  ready
  );
  modport sink (
    input  valid, new_value, write_size, status, dyn_kind, dyn_info, dyn_addend,
    output ready
  );
endinterface

// File: hw/rtl/rfp_cfg_regs.sv
// ----------------------------------------------------------------------------
// Relocation fixup patcher configuration registers
// APB-style register file holding the GOT and PLT base addresses.
// ----------------------------------------------------------------------------
module rfp_cfg_regs
  import rfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output logic [ADDR_W-1:0] got_base,
  output logic [ADDR_W-1:0] plt_base
);

  logic [ADDR_W-1:0] got_base_r;
  logic [ADDR_W-1:0] plt_base_r;
  logic              wr_en;
  logic              sel_plt;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  // Registers sit on 8-byte boundaries; only the doubleword select bit decodes.
  assign sel_plt = paddr[3] == CFG_PLT_ADDR[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      got_base_r <= '0;
      plt_base_r <= '0;
    end else if (wr_en) begin
      if (sel_plt) begin
        plt_base_r <= pwdata;
      end else begin
        got_base_r <= pwdata;
      end
    end
  end

  assign prdata   = sel_plt ? plt_base_r : got_base_r;
  assign got_base = got_base_r;
  assign plt_base = plt_base_r;

endmodule

// File: hw/rtl/rfp_target.sv
// ----------------------------------------------------------------------------
// Relocation fixup patcher target stage
// Decodes the record, selects the PLT, GOT or symbol target and early status.
// ----------------------------------------------------------------------------
module rfp_target
  import rfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rfp_rec_t          in_rec,
  input  logic [ADDR_W-1:0] got_base,
  input  logic [ADDR_W-1:0] plt_base,
  output logic              out_valid,
  input  logic              out_ready,
  output rfp_tgt_t          out_tgt
);

  logic              valid_r;
  rfp_tgt_t          tgt_r;
  rfp_tgt_t          tgt_nxt;
  logic [ADDR_W-1:0] plt_target;
  logic [ADDR_W-1:0] got_target;
  logic [ADDR_W-1:0] plt_hdr;
  logic              local_def;
  logic              dyn_nz;
  logic              undef_weak;

  assign plt_hdr    = (in_rec.op == OP_A64_CALL26) ? PLT_HDR_A64 : PLT_HDR_X86;
  assign plt_target = plt_base + plt_hdr + {{(ADDR_W-SLOT_W-4){1'b0}}, in_rec.slot, 4'b0};
  assign got_target = got_base + {{(ADDR_W-SLOT_W-3){1'b0}}, in_rec.slot, 3'b0};
  assign local_def  = in_rec.sym_defined && !in_rec.sym_dynamic;
  assign dyn_nz     = in_rec.sym_dynamic && (in_rec.sym_address != '0);
  assign undef_weak = !in_rec.sym_defined && in_rec.sym_weak;

  always_comb begin
    tgt_nxt.op     = in_rec.op;
    tgt_nxt.plan   = in_rec.plan;
    tgt_nxt.target = '0;
    tgt_nxt.addend = in_rec.addend;
    tgt_nxt.place  = in_rec.place_address;
    tgt_nxt.word   = in_rec.old_word;
    tgt_nxt.dsym   = in_rec.dyn_sym_index;
    tgt_nxt.status = ST_OK;
    unique case (in_rec.op)
      OP_NONE: begin
      end
      OP_X86_ABS64, OP_A64_ABS64: begin
        if (in_rec.op == OP_X86_ABS64 && in_rec.sym_redirected) begin
          tgt_nxt.op = OP_NONE;
        end else if (in_rec.plan != PLAN_DYN_ABS) begin
          tgt_nxt.target = in_rec.sym_address;
        end
      end
      OP_X86_PC32: begin
        priority if (in_rec.plan == PLAN_PLT) begin
          tgt_nxt.target = plt_target;
        end else if (in_rec.plan == PLAN_GOT) begin
          tgt_nxt.target = got_target;
        end else if (local_def || dyn_nz) begin
          tgt_nxt.target = in_rec.sym_address;
        end else if (undef_weak) begin
          tgt_nxt.target = '0;
        end else begin
          tgt_nxt.status = ST_UNRESOLVED;
        end
      end
      OP_X86_GOTPCREL: begin
        if (in_rec.plan == PLAN_GOT) begin
          tgt_nxt.target = got_target;
        end else begin
          tgt_nxt.status = ST_PLAN;
        end
      end
      OP_A64_CALL26: begin
        priority if (in_rec.plan == PLAN_PLT) begin
          tgt_nxt.target = plt_target;
        end else if (local_def) begin
          tgt_nxt.target = in_rec.sym_address;
        end else if (undef_weak) begin
          tgt_nxt.target = '0;
        end else begin
          tgt_nxt.status = ST_UNRESOLVED;
        end
      end
      OP_A64_ADRP, OP_A64_ADD_LO12, OP_A64_LD64_LO12, OP_A64_LD32_LO12: begin
        priority if (in_rec.plan == PLAN_GOT) begin
          tgt_nxt.target = got_target;
        end else if (local_def) begin
          tgt_nxt.target = in_rec.sym_address;
        end else if (undef_weak) begin
          tgt_nxt.target = '0;
        end else begin
          tgt_nxt.status = ST_UNRESOLVED;
        end
      end
      default: begin
        tgt_nxt.status = ST_KIND;
      end
    endcase
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tgt_r <= tgt_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_tgt   = tgt_r;

endmodule

// File: hw/rtl/rfp_arith.sv
// ----------------------------------------------------------------------------
// Relocation fixup patcher address arithmetic
// Two stages: target plus addend, then the PC-relative or page difference.
// ----------------------------------------------------------------------------
module rfp_arith
  import rfp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  rfp_tgt_t  in_tgt,
  output logic      out_valid,
  input  logic      out_ready,
  output rfp_diff_t out_diff
);

  logic              sum_valid_r;
  logic              sum_ready;
  rfp_sum_t          sum_r;
  rfp_sum_t          sum_nxt;
  logic              diff_valid_r;
  rfp_diff_t         diff_r;
  rfp_diff_t         diff_nxt;
  logic              is_adrp;
  logic [ADDR_W-1:0] lhs;
  logic [ADDR_W-1:0] rhs;

  always_comb begin
    sum_nxt.op     = in_tgt.op;
    sum_nxt.plan   = in_tgt.plan;
    sum_nxt.sa     = in_tgt.target + in_tgt.addend;
    sum_nxt.addend = in_tgt.addend;
    sum_nxt.place  = in_tgt.place;
    sum_nxt.word   = in_tgt.word;
    sum_nxt.dsym   = in_tgt.dsym;
    sum_nxt.status = in_tgt.status;
  end

  assign in_ready = !sum_valid_r || sum_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_valid_r <= 1'b0;
    end else if (in_ready) begin
      sum_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sum_r <= sum_nxt;
    end
  end

  // ADRP works on 4 KiB page numbers of both the target and the place.
  assign is_adrp = sum_r.op == OP_A64_ADRP;
  assign lhs     = is_adrp ? {sum_r.sa[ADDR_W-1:12], 12'b0} : sum_r.sa;
  assign rhs     = is_adrp ? {sum_r.place[ADDR_W-1:12], 12'b0} : sum_r.place;

  always_comb begin
    diff_nxt.op     = sum_r.op;
    diff_nxt.plan   = sum_r.plan;
    diff_nxt.sa     = sum_r.sa;
    diff_nxt.diff   = lhs - rhs;
    diff_nxt.addend = sum_r.addend;
    diff_nxt.word   = sum_r.word;
    diff_nxt.dsym   = sum_r.dsym;
    diff_nxt.status = sum_r.status;
  end

  assign sum_ready = !diff_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_valid_r <= 1'b0;
    end else if (sum_ready) begin
      diff_valid_r <= sum_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_valid_r && sum_ready) begin
      diff_r <= diff_nxt;
    end
  end

  assign out_valid = diff_valid_r;
  assign out_diff  = diff_r;

endmodule

// File: hw/rtl/rfp_pack.sv
// ----------------------------------------------------------------------------
// Relocation fixup patcher pack stage
// Range checks, instruction field patching and dynamic record build.
// ----------------------------------------------------------------------------
module rfp_pack
  import rfp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  rfp_diff_t in_diff,
  output logic      out_valid,
  input  logic      out_ready,
  output rfp_res_t  out_res
);

  logic        valid_r;
  rfp_res_t    res_r;
  rfp_res_t    res_nxt;
  logic        fits32;
  logic        fits28;
  logic        fits33;
  logic [11:0] imm;
  logic [WORD_W-1:0] w;
  logic [STATUS_W-1:0] st;

  assign fits32 = (in_diff.diff[63:31] == '0) || (in_diff.diff[63:31] == '1);
  assign fits28 = (in_diff.diff[63:27] == '0) || (in_diff.diff[63:27] == '1);
  assign fits33 = (in_diff.diff[63:32] == '0) || (in_diff.diff[63:32] == '1);
  assign w      = in_diff.word;

  always_comb begin
    unique case (in_diff.op)
      OP_A64_LD64_LO12: imm = {3'b0, in_diff.sa[11:3]};
      OP_A64_LD32_LO12: imm = {2'b0, in_diff.sa[11:2]};
      default:          imm = in_diff.sa[11:0];
    endcase
  end

  always_comb begin
    res_nxt = '0;
    st      = in_diff.status;
    if (st == ST_OK) begin
      unique case (in_diff.op)
        OP_X86_ABS64, OP_A64_ABS64: begin
          res_nxt.new_value  = in_diff.sa;
          res_nxt.write_size = WS_EIGHT;
          if (in_diff.plan == PLAN_DYN_ABS) begin
            res_nxt.dyn_kind   = DK_SYMBOLIC;
            res_nxt.dyn_info   = {in_diff.dsym, (in_diff.op == OP_X86_ABS64) ?
                                  RT_X86_ABS64 : RT_A64_ABS64};
            res_nxt.dyn_addend = in_diff.addend;
          end else if (in_diff.plan == PLAN_RELATIVE) begin
            res_nxt.dyn_kind   = DK_RELATIVE;
            res_nxt.dyn_info   = {32'b0, (in_diff.op == OP_X86_ABS64) ?
                                  RT_X86_RELATIVE : RT_A64_RELATIVE};
            res_nxt.dyn_addend = in_diff.sa;
          end
        end
        OP_X86_PC32, OP_X86_GOTPCREL: begin
          if (fits32) begin
            res_nxt.new_value  = {32'b0, in_diff.diff[31:0]};
            res_nxt.write_size = WS_FOUR;
          end else begin
            st = ST_RANGE;
          end
        end
        OP_A64_CALL26: begin
          if (fits28) begin
            res_nxt.new_value  = {32'b0, (w & ~MASK_B26) | {6'b0, in_diff.diff[27:2]}};
            res_nxt.write_size = WS_FOUR;
          end else begin
            st = ST_RANGE;
          end
        end
        OP_A64_ADRP: begin
          if (fits33) begin
            res_nxt.new_value  = {32'b0, (w & ~MASK_ADRP) |
                                  {1'b0, in_diff.diff[13:12], 5'b0,
                                   in_diff.diff[32:14], 5'b0}};
            res_nxt.write_size = WS_FOUR;
          end else begin
            st = ST_RANGE;
          end
        end
        OP_A64_ADD_LO12, OP_A64_LD64_LO12, OP_A64_LD32_LO12: begin
          res_nxt.new_value  = {32'b0, (w & ~MASK_LO12) | {10'b0, imm, 10'b0}};
          res_nxt.write_size = WS_FOUR;
        end
        default: begin
        end
      endcase
    end
    if (st != ST_OK) begin
      res_nxt = '0;
    end
    res_nxt.status = st;
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// File: hw/rtl/relocation_fixup_patcher_core.sv
// ----------------------------------------------------------------------------
// Relocation fixup patcher core
// Applies one x86-64 or AArch64 relocation record per word and returns the
// patched value, the dynamic relocation record and a status.
// ----------------------------------------------------------------------------
// The core takes one relocation word per clock while the output is not
// stalled and returns one result word for each. The
// pipeline has four register stages: target selection (PLT, GOT or symbol),
// the 64-bit target plus addend add, the 64-bit PC-relative or page
// difference, and range check with field patching into the output register;
// the wide adds set the stage depth. Ready ripples back through the stages,
// so a stall holds every word in place and a gap in the pipeline is filled
// even while the output waits. The GOT base sits at byte address 0x0 and the
// PLT base at 0x8 of the 64-bit configuration port; write them only while
// no word is in flight.
module relocation_fixup_patcher_core
  import rfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  rfp_in_if.sink            in_ch,
  rfp_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [ADDR_W-1:0] got_base;
  logic [ADDR_W-1:0] plt_base;
  rfp_rec_t          rec;
  logic              tgt_valid;
  logic              tgt_ready;
  rfp_tgt_t          tgt;
  logic              diff_valid;
  logic              diff_ready;
  rfp_diff_t         diff;
  rfp_res_t          res;

  rfp_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .pready   (cfg_pready),
    .got_base (got_base),
    .plt_base (plt_base)
  );

  always_comb begin
    rec.op             = in_ch.op;
    rec.plan           = in_ch.plan;
    rec.slot           = in_ch.slot;
    rec.sym_address    = in_ch.sym_address;
    rec.sym_defined    = in_ch.sym_defined;
    rec.sym_dynamic    = in_ch.sym_dynamic;
    rec.sym_weak       = in_ch.sym_weak;
    rec.sym_redirected = in_ch.sym_redirected;
    rec.addend         = in_ch.addend;
    rec.place_address  = in_ch.place_address;
    rec.old_word       = in_ch.old_word;
    rec.dyn_sym_index  = in_ch.dyn_sym_index;
  end

  rfp_target u_target (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_rec    (rec),
    .got_base  (got_base),
    .plt_base  (plt_base),
    .out_valid (tgt_valid),
    .out_ready (tgt_ready),
    .out_tgt   (tgt)
  );

  rfp_arith u_arith (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (tgt_valid),
    .in_ready  (tgt_ready),
    .in_tgt    (tgt),
    .out_valid (diff_valid),
    .out_ready (diff_ready),
    .out_diff  (diff)
  );

  rfp_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (diff_valid),
    .in_ready  (diff_ready),
    .in_diff   (diff),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  assign out_ch.new_value  = res.new_value;
  assign out_ch.write_size = res.write_size;
  assign out_ch.status     = res.status;
  assign out_ch.dyn_kind   = res.dyn_kind;
  assign out_ch.dyn_info   = res.dyn_info;
  assign out_ch.dyn_addend = res.dyn_addend;

  a_err_clears_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status != ST_OK) |->
      (out_ch.new_value == '0) && (out_ch.write_size == WS_NONE) &&
      (out_ch.dyn_kind == DK_NONE))
    else $error("failed word carries a write or a dynamic record");

  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.write_size == WS_NONE) |-> (out_ch.new_value == '0))
    else $error("value present without a write");

  a_no_dyn_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.dyn_kind == DK_NONE) |->
      (out_ch.dyn_info == '0) && (out_ch.dyn_addend == '0))
    else $error("dynamic record fields set without a record");

  a_dyn_needs_eight: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.dyn_kind != DK_NONE) |-> (out_ch.write_size == WS_EIGHT))
    else $error("dynamic record on a four byte patch");

endmodule
